// File: sv/websocket_frame_tracker_assert.svh
// Assertion macros used by the checker file.
`ifndef WEBSOCKET_FRAME_TRACKER_ASSERT_SVH
`define WEBSOCKET_FRAME_TRACKER_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define WSFT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("websocket frame tracker check failed");

// Next-cycle implication, ignored while reset is held.
`define WSFT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("websocket frame tracker check failed");

// Next-cycle implication that is also checked across reset.
`define WSFT_ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("websocket frame tracker check failed");

`endif

// File: sv/wsft_pkg.sv
package wsft_pkg;

    // Parser stages of one frame.
    typedef enum logic [2:0] {
        ST_HEADER = 3'd0,
        ST_LEN    = 3'd1,
        ST_EXT    = 3'd2,
        ST_MASK   = 3'd3,
        ST_DATA   = 3'd4
    } t_stage;

    // Seven-bit length codes that announce an extended length.
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Byte counts of the extended lengths and of the masking key.
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam int         KEY_BYTES   = 4;

    localparam int DATA_IN_BITS  = 8;
    localparam int WORD_OUT_BITS = 136;

    // One completed frame, last field in the lowest bits.
    typedef struct packed {
        logic [63:0] message_length;
        logic [63:0] payload_length;
        logic        was_masked;
        logic        final_fragment;
        logic [3:0]  frame_opcode;
    } t_frame_result;

    localparam int RESULT_BITS = $bits(t_frame_result);

endpackage

// File: sv/wsft_parser.sv
module wsft_parser
    import wsft_pkg::*;
#(
    parameter int LENGTH_BITS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [DATA_IN_BITS-1:0] i_data,
    output logic                    o_emit,
    output t_frame_result           o_result
);

    t_stage                 r_stage,   n_stage;
    logic [3:0]             r_opcode,  n_opcode;
    logic                   r_final,   n_final;
    logic                   r_masked,  n_masked;
    logic [LENGTH_BITS-1:0] r_frame,   n_frame;
    logic [LENGTH_BITS-1:0] r_seen,    n_seen;
    logic [3:0]             r_left,    n_left;
    logic [63:0]            r_message, n_message;

    logic                   length_done;
    logic [LENGTH_BITS-1:0] seen_inc;
    logic [3:0]             left_dec;

    assign seen_inc = r_seen + LENGTH_BITS'(1);
    assign left_dec = (r_left != 4'd0) ? (r_left - 4'd1) : 4'd0;

    // Next state for one accepted byte.
    always_comb begin
        n_stage     = r_stage;
        n_opcode    = r_opcode;
        n_final     = r_final;
        n_masked    = r_masked;
        n_frame     = r_frame;
        n_seen      = r_seen;
        n_left      = r_left;
        n_message   = r_message;
        length_done = 1'b0;
        o_emit      = 1'b0;

        if (i_accept) begin
            case (r_stage)
                ST_LEN: begin
                    n_masked = i_data[7];
                    if (i_data[6:0] == LEN_EXT16) begin
                        n_left  = EXT16_BYTES;
                        n_frame = '0;
                        n_stage = ST_EXT;
                    end else if (i_data[6:0] == LEN_EXT64) begin
                        n_left  = EXT64_BYTES;
                        n_frame = '0;
                        n_stage = ST_EXT;
                    end else begin
                        n_frame     = LENGTH_BITS'(i_data[6:0]);
                        length_done = 1'b1;
                    end
                end
                ST_EXT: begin
                    // Big-endian length; bits above the register width drop out.
                    n_frame     = {r_frame[LENGTH_BITS-9:0], i_data};
                    n_left      = left_dec;
                    length_done = (left_dec == 4'd0);
                end
                ST_MASK: begin
                    if (seen_inc >= LENGTH_BITS'(KEY_BYTES)) begin
                        n_seen = '0;
                        if (r_frame == '0) begin
                            o_emit  = 1'b1;
                            n_stage = ST_HEADER;
                        end else begin
                            n_stage = ST_DATA;
                        end
                    end else begin
                        n_seen = seen_inc;
                    end
                end
                ST_DATA: begin
                    if (r_message != '1) begin
                        n_message = r_message + 64'd1;
                    end
                    n_seen = seen_inc;
                    if (seen_inc >= r_frame) begin
                        o_emit  = 1'b1;
                        n_stage = ST_HEADER;
                    end
                end
                default: begin
                    // Header byte; unused stage codes behave the same way.
                    n_opcode = i_data[3:0];
                    n_final  = i_data[7];
                    if (i_data[3:0] != 4'd0) begin
                        n_message = '0;
                    end
                    n_frame = '0;
                    n_seen  = '0;
                    n_left  = 4'd0;
                    n_stage = ST_LEN;
                end
            endcase

            // The length is known: go to the key, the payload, or finish now.
            if (length_done) begin
                n_seen = '0;
                if (n_masked) begin
                    n_stage = ST_MASK;
                end else if (n_frame == '0) begin
                    o_emit  = 1'b1;
                    n_stage = ST_HEADER;
                end else begin
                    n_stage = ST_DATA;
                end
            end
        end
    end

    // The result is taken from the updated state.
    always_comb begin
        o_result.frame_opcode   = n_opcode;
        o_result.final_fragment = n_final;
        o_result.was_masked     = n_masked;
        o_result.payload_length = 64'(n_frame);
        o_result.message_length = n_message;
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage   <= ST_HEADER;
            r_opcode  <= 4'd0;
            r_final   <= 1'b0;
            r_masked  <= 1'b0;
            r_frame   <= '0;
            r_seen    <= '0;
            r_left    <= 4'd0;
            r_message <= '0;
        end else begin
            r_stage   <= n_stage;
            r_opcode  <= n_opcode;
            r_final   <= n_final;
            r_masked  <= n_masked;
            r_frame   <= n_frame;
            r_seen    <= n_seen;
            r_left    <= n_left;
            r_message <= n_message;
        end
    end

endmodule

// File: sv/websocket_frame_tracker.sv
// Channel  | Dir | Word bits                                   | Moves
// s_axis   | in  | [7:0] data_byte                             | one stream byte
// m_axis   | out | [3:0] frame_opcode, [4] final_fragment,     | one completed frame
//          |     | [5] was_masked, [69:6] payload_length,      |
//          |     | [133:70] message_length, [135:134] zero     |
//
// One byte is taken per cycle; the parser state updates in that same cycle.
// A frame result is loaded into the output register in the cycle after its closing byte.
// Input stalls only when that output register is full and not being taken.
// Reset (i_rst_n low, synchronous) returns the parser to the header stage and
// empties the output register.
module websocket_frame_tracker
    import wsft_pkg::*;
#(
    parameter int LENGTH_BITS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [DATA_IN_BITS-1:0]  i_s_axis_tdata,  // [7:0] data_byte
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // [3:0] frame_opcode, [4] final_fragment, [5] was_masked,
    // [69:6] payload_length, [133:70] message_length
    output logic [WORD_OUT_BITS-1:0] o_m_axis_tdata
);

    logic          accept;
    logic          emit;
    t_frame_result result;
    logic          r_out_valid;
    t_frame_result r_out;

    // A byte goes in whenever the output register is free or emptying.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    wsft_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_s_axis_tdata),
        .o_emit   (emit),
        .o_result (result)
    );

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(WORD_OUT_BITS - RESULT_BITS)'(0), r_out};

endmodule

// File: sv/wsft_checker.sv
`include "websocket_frame_tracker_assert.svh"

module wsft_checker
    import wsft_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_s_axis_tvalid,
    input logic                     o_s_axis_tready,
    input logic                     o_m_axis_tvalid,
    input logic                     i_m_axis_tready,
    input logic [WORD_OUT_BITS-1:0] o_m_axis_tdata
);

    logic stalled;
    logic in_word;

    assign stalled = o_m_axis_tvalid && !i_m_axis_tready;
    assign in_word = i_s_axis_tvalid && o_s_axis_tready;

    // A stalled result stays offered.
    `WSFT_ASSERT_NEXT(a_out_hold, stalled, o_m_axis_tvalid)
    // A stalled result keeps its bits.
    `WSFT_ASSERT_NEXT(a_out_stable, stalled, $stable(o_m_axis_tdata))
    // Reset empties the output register.
    `WSFT_ASSERT_NEXT_ALWAYS(a_rst_empty, !i_rst_n, !o_m_axis_tvalid)
    // A new result only follows an accepted byte.
    `WSFT_ASSERT_NOW(a_out_cause, $rose(o_m_axis_tvalid), $past(in_word))
    // The input is never refused while the output register is empty.
    `WSFT_ASSERT_NOW(a_ready_free, !o_m_axis_tvalid, o_s_axis_tready)

endmodule

bind websocket_frame_tracker wsft_checker u_wsft_checker (.*);
